// File: src/mms_pkg.sv
// mms_pkg: shared constants and types for the markdown markup stripper
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mms_pkg;

  // character codes the stripper reacts to
  localparam logic [7:0] CharTick    = 8'h60;
  localparam logic [7:0] CharHash    = 8'h23;
  localparam logic [7:0] CharStar    = 8'h2A;
  localparam logic [7:0] CharUnder   = 8'h5F;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharNewline = 8'h0A;

  // most results one input item can cause
  localparam int unsigned MaxResults = 3;

  // result group queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // all results caused by one input item
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes; // result bytes in output order, entry 0 first
    logic [1:0]                 cnt;   // number of results, 1 to 3
    logic                       bare;  // single end marker with no byte
    logic                       eot;   // group closes the text
  } mms_group_t;

  // ascii digit or letter
  function automatic logic is_alnum(input logic [7:0] b);
    is_alnum = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A);
  endfunction

endpackage

// File: src/mms_front.sv
// mms_front: accepts raw bytes, tracks markup state and builds result groups
// depends on mms_pkg
`timescale 1ns / 1ps

module mms_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               in_last_i,
  output logic               push_o,
  output mms_pkg::mms_group_t push_group_o,
  input  logic               push_ready_i
);
  import mms_pkg::*;

  logic       code_q, code_d;
  logic       ls_q, ls_d;
  logic       hs_q, hs_d;
  logic       fs_q, fs_d;
  logic [1:0] ht_q, ht_d;
  logic       uh_q, uh_d;
  logic       dn_q, dn_d;
  logic       prev_q, prev_d;

  logic                       accept;
  logic [1:0]                 cnt;
  logic [MaxResults-1:0][7:0] byt;
  logic                       dec;
  logic                       dprev;
  logic                       bare;

  // the front stalls only when the queue has no room
  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & push_ready_i;

  // classify one byte and collect its results
  always_comb begin
    code_d = code_q;
    ls_d   = ls_q;
    hs_d   = hs_q;
    fs_d   = fs_q;
    ht_d   = ht_q;
    uh_d   = uh_q;
    dn_d   = dn_q;
    cnt    = 2'd0;
    byt    = '0;
    dec    = 1'b0;
    dprev  = 1'b0;
    bare   = 1'b0;

    // pending state resolved by this byte
    if (fs_q) begin
      if (in_byte_i == CharNewline) fs_d = 1'b0;
    end else if (hs_q) begin
      if (in_byte_i != CharHash && in_byte_i != CharSpace) begin
        hs_d  = 1'b0;
        dec   = 1'b1;
        dprev = prev_q;
      end
    end else if (dn_q) begin
      dn_d = 1'b0;
      if (in_byte_i != CharUnder) begin
        dec   = 1'b1;
        dprev = prev_q;
      end
    end else if (uh_q) begin
      uh_d = 1'b0;
      if (is_alnum(in_byte_i)) begin
        byt[cnt] = CharUnder;
        cnt      = cnt + 2'd1;
        ls_d     = 1'b0;
        dec      = 1'b1;
      end else if (in_byte_i != CharUnder) begin
        dec = 1'b1;
      end
    end else if (ht_q != 2'd0) begin
      if (in_byte_i == CharTick) begin
        if (ht_q >= 2'd2) begin
          ht_d   = 2'd0;
          code_d = ~code_q;
          fs_d   = 1'b1;
          ls_d   = 1'b1;
        end else begin
          ht_d = ht_q + 2'd1;
        end
      end else begin
        // held ticks that are no fence
        if (code_q) begin
          for (int k = 0; k < 2; k++) begin
            if (k < int'(ht_q) && cnt != 2'd3) begin
              byt[cnt] = CharTick;
              cnt      = cnt + 2'd1;
            end
          end
          ls_d = 1'b0;
        end
        ht_d = 2'd0;
        dec  = 1'b1;
      end
    end else begin
      dec   = 1'b1;
      dprev = prev_q;
    end

    // ordinary handling of the byte
    if (dec) begin
      if (ls_d && in_byte_i == CharTick) begin
        ht_d = 2'd1;
      end else if (code_d) begin
        if (cnt != 2'd3) begin
          byt[cnt] = in_byte_i;
          cnt      = cnt + 2'd1;
        end
        ls_d = (in_byte_i == CharNewline);
      end else if (ls_d && in_byte_i == CharHash) begin
        hs_d = 1'b1;
        ls_d = 1'b0;
      end else if (in_byte_i == CharStar || in_byte_i == CharTick) begin
        // markup dropped
      end else if (in_byte_i == CharUnder) begin
        if (dprev) uh_d = 1'b1;
        else dn_d = 1'b1;
      end else begin
        if (cnt != 2'd3) begin
          byt[cnt] = in_byte_i;
          cnt      = cnt + 2'd1;
        end
        ls_d = (in_byte_i == CharNewline);
      end
    end

    prev_d = is_alnum(in_byte_i);

    // end of text: flush held ticks in code mode, mark the end, start over
    if (in_last_i) begin
      if (code_d) begin
        for (int k = 0; k < 2; k++) begin
          if (k < int'(ht_d) && cnt != 2'd3) begin
            byt[cnt] = CharTick;
            cnt      = cnt + 2'd1;
          end
        end
      end
      if (cnt == 2'd0) begin
        cnt  = 2'd1;
        bare = 1'b1;
      end
      code_d = 1'b0;
      ls_d   = 1'b1;
      hs_d   = 1'b0;
      fs_d   = 1'b0;
      ht_d   = 2'd0;
      uh_d   = 1'b0;
      dn_d   = 1'b0;
      prev_d = 1'b0;
    end
  end

  // group toward the queue
  assign push_o             = accept & (cnt != 2'd0);
  assign push_group_o.bytes = byt;
  assign push_group_o.cnt   = cnt;
  assign push_group_o.bare  = bare;
  assign push_group_o.eot   = in_last_i;

  // markup state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= 1'b0;
      ls_q   <= 1'b1;
      hs_q   <= 1'b0;
      fs_q   <= 1'b0;
      ht_q   <= 2'd0;
      uh_q   <= 1'b0;
      dn_q   <= 1'b0;
      prev_q <= 1'b0;
    end else if (accept) begin
      code_q <= code_d;
      ls_q   <= ls_d;
      hs_q   <= hs_d;
      fs_q   <= fs_d;
      ht_q   <= ht_d;
      uh_q   <= uh_d;
      dn_q   <= dn_d;
      prev_q <= prev_d;
    end
  end

endmodule

// File: src/mms_queue.sv
// mms_queue: short queue of result groups between front and back
// depends on mms_pkg
`timescale 1ns / 1ps

module mms_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mms_pkg::mms_group_t push_group_i,
  output logic               push_ready_o,
  output logic               head_valid_o,
  output mms_pkg::mms_group_t head_group_o,
  input  logic               pop_i
);
  import mms_pkg::*;

  mms_group_t           mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, wr_d;
  logic [QueuePtrW-1:0] rd_q, rd_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready_o = (cnt_q != QueueCntW'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_group_o = mem_q[rd_q];
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & head_valid_o;

  // pointer and fill updates
  always_comb begin
    wr_d  = do_push ? wr_q + QueuePtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QueuePtrW'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + QueueCntW'(1);
    if (!do_push && do_pop) cnt_d = cnt_q - QueueCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // group storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_group_i;
  end

endmodule

// File: src/mms_back.sv
// mms_back: walks each result group and presents one result per cycle while a group waits and the output is ready
// depends on mms_pkg
`timescale 1ns / 1ps

module mms_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  mms_pkg::mms_group_t head_group_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               out_byte_valid_o,
  output logic               out_eot_o
);
  import mms_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       bvalid_q;
  logic       eot_q;
  logic       load;
  logic       at_end;

  assign load   = head_valid_i & (~valid_q | out_ready_i);
  assign at_end = (idx_q == head_group_i.cnt - 2'd1);
  assign pop_o  = load & at_end;

  // result index and output valid
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = at_end ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= head_group_i.bytes[idx_q];
      bvalid_q <= ~head_group_i.bare;
      eot_q    <= head_group_i.eot & at_end;
    end
  end

  assign out_valid_o      = valid_q;
  assign out_byte_o       = bvalid_q ? byte_q : 8'h00;
  assign out_byte_valid_o = bvalid_q;
  assign out_eot_o        = eot_q;

endmodule

// File: src/markdown_markup_stripper_top.sv
// markdown markup stripper: one raw byte per cycle in while the queue has room, plain
// text bytes out. path: the results of a byte are written to the group queue when the
// byte is accepted and are then loaded into the output register of the back.
// throughput: one byte per cycle in while the queue has room, one result per cycle out while the
// output is ready; the four-group queue absorbs items that cause two or three results and stalls
// input when full. reset: asynchronous active low; code mode off, at line start, nothing held.
`timescale 1ns / 1ps

module markdown_markup_stripper_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] s_tdata_i,   // [7:0] in_byte
  input  logic       s_tlast_i,   // in_last
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,   // [7:0] out_byte
  output logic       m_tuser_o,   // [0] byte_valid
  output logic       m_tlast_o    // end_of_text
);
  import mms_pkg::*;

  logic       push;
  mms_group_t push_group;
  logic       push_ready;
  logic       head_valid;
  mms_group_t head_group;
  logic       pop;

  // classification and markup state
  mms_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_tvalid_i),
    .in_ready_o   (s_tready_o),
    .in_byte_i    (s_tdata_i),
    .in_last_i    (s_tlast_i),
    .push_o       (push),
    .push_group_o (push_group),
    .push_ready_i (push_ready)
  );

  // result group queue
  mms_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_group_i (push_group),
    .push_ready_o (push_ready),
    .head_valid_o (head_valid),
    .head_group_o (head_group),
    .pop_i        (pop)
  );

  // serializer and output register
  mms_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_group_i     (head_group),
    .pop_o            (pop),
    .out_valid_o      (m_tvalid_o),
    .out_ready_i      (m_tready_i),
    .out_byte_o       (m_tdata_o),
    .out_byte_valid_o (m_tuser_o),
    .out_eot_o        (m_tlast_o)
  );

endmodule
